### rtl/http_chunked_body_decoder_top_defines.svh
// assertion macros for the chunked body decoder checker
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HCBD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcbd check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define HCBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbd check failed");

`endif

### rtl/hcbd_pkg.sv
// types and constants shared by the chunked body decoder modules
`timescale 1ns / 1ps
package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       body_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       body_done;
        logic       size_overflow;
    } out_item_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       body_start;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_lf;
        logic       is_blank;
    } cls_item_t;

    typedef enum logic [5:0] {
        PH_DIGITS = 6'b000001,
        PH_EXT    = 6'b000010,
        PH_DATA   = 6'b000100,
        PH_TRAIL1 = 6'b001000,
        PH_TRAIL2 = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

endpackage

### rtl/hcbd_front.sv
// front end: accepts bytes and classifies them as hex digit, line feed or blank
`timescale 1ns / 1ps
module hcbd_front (
    input  logic                in_valid,
    output logic                in_stall,
    input  hcbd_pkg::in_item_t  in_item,
    output logic                push,
    output hcbd_pkg::cls_item_t push_item,
    input  logic                q_full
);
    import hcbd_pkg::*;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_NL = 8'h0a;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_HT = 8'h09;

    logic       is_dec;
    logic       is_low;
    logic       is_up;
    logic [7:0] c;

    assign c      = in_item.in_byte;
    assign is_dec = (c >= CH_0)  && (c <= CH_9);
    assign is_low = (c >= CH_LA) && (c <= CH_LF);
    assign is_up  = (c >= CH_UA) && (c <= CH_UF);

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_item            = '0;
        push_item.data       = c;
        push_item.body_start = in_item.body_start;
        push_item.is_hex     = is_dec || is_low || is_up;
        push_item.is_lf      = (c == CH_NL);
        push_item.is_blank   = (c == CH_SP) || (c == CH_HT);
        if (is_dec)
        begin
            push_item.hex_val = c[3:0];
        end
        else if (is_low || is_up)
        begin
            // 'a'..'f' and 'A'..'F' have low bits 1..6
            push_item.hex_val = c[3:0] + 4'd9;
        end
        else
        begin
            push_item.hex_val = 4'd0;
        end
    end

endmodule

### rtl/hcbd_queue.sv
// short fifo of classified items between front and back
`timescale 1ns / 1ps
module hcbd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hcbd_pkg::cls_item_t push_item,
    output logic                full,
    output logic                head_valid,
    output hcbd_pkg::cls_item_t head_item,
    input  logic                pop
);
    import hcbd_pkg::*;

    cls_item_t            mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic [Q_CNT_W-1:0]   cnt_next;
    logic                 do_pop;

    assign full       = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/hcbd_back.sv
// back end: chunk parse state machine, size counter and output register
`timescale 1ns / 1ps
module hcbd_back #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  hcbd_pkg::cls_item_t head_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output hcbd_pkg::out_item_t out_item
);
    import hcbd_pkg::*;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    phase_t                 phase_cur;
    logic [SIZE_BITS-1:0]   cnt_reg;
    logic [SIZE_BITS-1:0]   cnt_next;
    logic [SIZE_BITS-1:0]   cnt_cur;
    logic                   seen_reg;
    logic                   seen_next;
    logic                   seen_cur;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   ovf_cur;
    logic                   out_valid_reg;
    out_item_t              out_item_reg;
    out_item_t              res;

    assign pop       = head_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        phase_cur = phase_reg;
        cnt_cur   = cnt_reg;
        seen_cur  = seen_reg;
        ovf_cur   = ovf_reg;
        // a new body clears everything before its first byte is parsed
        if (head_item.body_start)
        begin
            phase_cur = PH_DIGITS;
            cnt_cur   = '0;
            seen_cur  = 1'b0;
            ovf_cur   = 1'b0;
        end

        phase_next        = phase_cur;
        cnt_next          = cnt_cur;
        seen_next         = seen_cur;
        ovf_next          = ovf_cur;
        res               = '0;

        unique case (phase_cur)
            PH_DIGITS:
            begin
                if (head_item.is_hex)
                begin
                    seen_next = 1'b1;
                    // any bit in the top nibble means the shift would spill
                    if (|cnt_cur[SIZE_BITS-1 -: 4])
                    begin
                        cnt_next = '1;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = {cnt_cur[SIZE_BITS-5:0], head_item.hex_val};
                    end
                end
                else if (head_item.is_lf)
                begin
                    phase_next = (cnt_cur == '0) ? PH_DONE : PH_DATA;
                end
                else if (head_item.is_blank && !seen_cur)
                begin
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_EXT;
                end
            end
            PH_EXT:
            begin
                if (head_item.is_lf)
                begin
                    phase_next = (cnt_cur == '0) ? PH_DONE : PH_DATA;
                end
            end
            PH_DATA:
            begin
                res.payload_byte  = head_item.data;
                res.payload_valid = 1'b1;
                cnt_next          = cnt_cur - SIZE_BITS'(1);
                if (cnt_cur == SIZE_BITS'(1))
                begin
                    phase_next = PH_TRAIL1;
                end
            end
            PH_TRAIL1:
            begin
                phase_next = PH_TRAIL2;
            end
            PH_TRAIL2:
            begin
                phase_next = PH_DIGITS;
                cnt_next   = '0;
                seen_next  = 1'b0;
            end
            default:
            begin
                phase_next = phase_cur;
            end
        endcase

        res.body_done     = (phase_next == PH_DONE);
        res.size_overflow = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DIGITS;
            cnt_reg       <= '0;
            seen_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                seen_reg  <= seen_next;
                ovf_reg   <= ovf_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= res;
        end
    end

endmodule

### rtl/http_chunked_body_decoder_top.sv
// HTTP/1.1 chunked body decoder: top level
// Usage:
//   input channel: one raw body byte per item (in_item.in_byte), with
//   in_item.body_start set on the first byte of a new body.
//   output channel: exactly one item per input item, carrying the decoded
//   payload byte (payload_valid set for data bytes, byte zero otherwise),
//   body_done once the zero-size line has ended and a sticky size_overflow.
// Path: an accepted item is written into the queue, then registered at the output.
// Throughput: one item per cycle while out_stall is low; the parse state machine in the back end
//   updates its phase and SIZE_BITS wide count once per item.
// A four-entry queue of classified bytes sits between front and back, and
// the back end drives a registered output, so up to five items are held
// while the receiver stalls; after that in_stall rises until room frees up.
// Reset (rst_n low, asynchronous) empties the queue, drops the output item
// and puts the parser at the start of a size line with a zero count.
`timescale 1ns / 1ps
module http_chunked_body_decoder_top #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  hcbd_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output hcbd_pkg::out_item_t out_item
);
    import hcbd_pkg::*;

    logic      push;
    cls_item_t push_item;
    logic      q_full;
    logic      head_valid;
    cls_item_t head_item;
    logic      pop;

    hcbd_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    hcbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    hcbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

### rtl/hcbd_checker.sv
// port-level checker for the chunked body decoder, bound to the top level
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_top_defines.svh"
module hcbd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input hcbd_pkg::in_item_t  in_item,
    input logic                out_valid,
    input logic                out_stall,
    input hcbd_pkg::out_item_t out_item
);
    import hcbd_pkg::*;

    `HCBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
    `HCBD_ASSERT_NOW(a_idle_byte_zero, out_valid && !out_item.payload_valid, out_item.payload_byte == 8'd0)
    `HCBD_ASSERT_NOW(a_done_no_data, out_valid && out_item.body_done, !out_item.payload_valid)
    // the queue only fills up behind a held output item
    `HCBD_ASSERT_NOW(a_stall_needs_out, in_stall, out_valid)
    // a stalled input item stays offered and unchanged
    `HCBD_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_item))

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

### dv/chunked_decode_compare.sv
// watches both channels of the chunked body decoder, predicts each output item and compares
`timescale 1ns / 1ps
module chunked_decode_compare
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item,
    output int        errors,
    output int        outstanding
);

    localparam logic [63:0] COUNT_MAX = (64'd1 << SIZE_BITS) - 64'd1;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_TAB    = 8'h09;
    localparam logic [7:0]  CH_SP     = 8'h20;

    phase_t      phase;
    logic [63:0] chunk_left;
    logic        digit_seen;
    logic        ovf_sticky;
    out_item_t   decoded_q[$];
    int          mismatch_n;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void end_size_line();
        if (chunk_left == 64'd0)
            phase = PH_DONE;
        else
            phase = PH_DATA;
    endfunction

    function automatic out_item_t decode_byte(input in_item_t it);
        out_item_t r;
        int        d;
        r = '0;
        if (it.body_start)
        begin
            phase      = PH_DIGITS;
            chunk_left = 64'd0;
            digit_seen = 1'b0;
            ovf_sticky = 1'b0;
        end
        d = hex_digit(it.in_byte);
        case (phase)
            PH_DIGITS:
            begin
                if (d >= 0)
                begin
                    digit_seen = 1'b1;
                    if (chunk_left > (COUNT_MAX >> 4))
                    begin
                        chunk_left = COUNT_MAX;
                        ovf_sticky = 1'b1;
                    end
                    else
                    begin
                        chunk_left = chunk_left * 64'd16 + 64'(d);
                        if (chunk_left > COUNT_MAX)
                        begin
                            chunk_left = COUNT_MAX;
                            ovf_sticky = 1'b1;
                        end
                    end
                end
                else if (it.in_byte == CH_LF)
                    end_size_line();
                else if (!((it.in_byte == CH_SP || it.in_byte == CH_TAB) && !digit_seen))
                    phase = PH_EXT;
                // blanks ahead of the first digit leave the line as it is
            end
            PH_EXT:
            begin
                if (it.in_byte == CH_LF)
                    end_size_line();
            end
            PH_DATA:
            begin
                r.payload_byte  = it.in_byte;
                r.payload_valid = 1'b1;
                chunk_left      = (chunk_left - 64'd1) & COUNT_MAX;
                if (chunk_left == 64'd0)
                    phase = PH_TRAIL1;
            end
            PH_TRAIL1:
                phase = PH_TRAIL2;
            PH_TRAIL2:
            begin
                phase      = PH_DIGITS;
                chunk_left = 64'd0;
                digit_seen = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.body_done     = (phase == PH_DONE);
        r.size_overflow = ovf_sticky;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        if (mismatch_n < 10)
            $display("%0t: mismatch on %s, expected %h, got %h", $realtime, what, want, got);
        mismatch_n++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : compare
        out_item_t want;
        if (!rst_n)
        begin
            phase      = PH_DIGITS;
            chunk_left = 64'd0;
            digit_seen = 1'b0;
            ovf_sticky = 1'b0;
            decoded_q.delete();
            mismatch_n = 0;
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            // output side first, so an item accepted now cannot answer its own result
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                    note_mismatch("item with nothing expected", 8'h00, out_item.payload_byte);
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_item.payload_byte !== want.payload_byte)
                        note_mismatch("payload_byte", want.payload_byte, out_item.payload_byte);
                    if (out_item.payload_valid !== want.payload_valid)
                        note_mismatch("payload_valid", 8'(want.payload_valid),
                                      8'(out_item.payload_valid));
                    if (out_item.body_done !== want.body_done)
                        note_mismatch("body_done", 8'(want.body_done), 8'(out_item.body_done));
                    if (out_item.size_overflow !== want.size_overflow)
                        note_mismatch("size_overflow", 8'(want.size_overflow),
                                      8'(out_item.size_overflow));
                end
            end
            if (in_valid && !in_stall)
                decoded_q.push_back(decode_byte(in_item));
            errors      <= mismatch_n;
            outstanding <= decoded_q.size();
        end
    end

endmodule

### dv/http_chunked_body_decoder_top_tb.sv
// stimulus and verdict for the chunked body decoder, with the compare module beside it
`timescale 1ns / 1ps
module http_chunked_body_decoder_top_tb;

    import hcbd_pkg::*;

    localparam int unsigned IDLE_PCT    = 23;
    localparam int unsigned ITEM_TARGET = 1450;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam logic [7:0]  CH_LF       = 8'h0A;
    localparam logic [7:0]  CH_CR       = 8'h0D;
    localparam logic [7:0]  CH_TAB      = 8'h09;
    localparam logic [7:0]  CH_SP       = 8'h20;
    localparam logic [7:0]  CH_SEMI     = 8'h3B;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    in_item_t  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    out_item_t out_item;
    int        errors;
    int        outstanding;

    int unsigned tx_idle_pct = IDLE_PCT;
    int unsigned rx_idle_pct = IDLE_PCT;
    int unsigned sent_n      = 0;
    bit          new_body    = 1'b0;
    bit          hold_req    = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    http_chunked_body_decoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    chunked_decode_compare u_compare (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) return "0" + 8'(nib);
        return (upper ? "A" : "a") + 8'(nib) - 8'd10;
    endfunction

    function automatic int unsigned chunk_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(1, 8);
        if (r < 93) return $urandom_range(9, 40);
        return $urandom_range(41, 200);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{in_byte: b, body_start: new_body};
        new_body  = 1'b0;
        sent_n++;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_size_line(input logic [47:0] size);
        int         ndig;
        logic [7:0] b;
        ndig = 1;
        while (ndig < 12 && (size >> (4 * ndig)) != 48'd0) ndig++;
        if ($urandom_range(3) == 0) ndig += $urandom_range(1, 2);
        if (ndig > 12) ndig = 12;
        repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
            send_byte($urandom_range(1) ? CH_SP : CH_TAB);
        for (int i = ndig - 1; i >= 0; i--)
            send_byte(hex_char(size[i*4 +: 4], $urandom_range(1)));
        // extension: anything up to the line feed
        if ($urandom_range(3) == 0)
        begin
            send_byte($urandom_range(1) ? CH_SEMI : CH_SP);
            repeat ($urandom_range(4))
            begin
                b = 8'($urandom);
                if (b == CH_LF) b = CH_SEMI;
                send_byte(b);
            end
        end
        if ($urandom_range(7) != 0) send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_chunk(input int unsigned len);
        send_size_line(48'(len));
        repeat (len) send_byte(8'($urandom));
        if ($urandom_range(7) == 0)
        begin
            send_byte(8'($urandom));
            send_byte(8'($urandom));
        end
        else
        begin
            send_byte(CH_CR);
            send_byte(CH_LF);
        end
    endtask

    task automatic send_body();
        new_body = 1'b1;
        repeat ($urandom_range(4)) send_chunk(chunk_len());
        if ($urandom_range(3) != 0)
            send_size_line(48'd0);
        else
        begin
            // last line without any digit
            if ($urandom_range(1)) send_byte(CH_CR);
            send_byte(CH_LF);
        end
        repeat ($urandom_range(2)) send_byte(8'($urandom));
    endtask

    initial
    begin : stimulus
        int unsigned pick;
        int unsigned len;
        bit          held;
        bit          paused;
        bit          quiet;
        held   = 1'b0;
        paused = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // blanks, extension, data extremes, odd trailer, empty last line, bytes after done
        new_body = 1'b1;
        send_byte(CH_SP);
        send_byte(CH_TAB);
        send_byte("2");
        send_byte(CH_SEMI);
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte("x");
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte("Z");
        // saturating size, then a new body clears the flag
        new_body = 1'b1;
        send_byte("f");
        send_byte("F");
        send_byte("f");
        send_byte("F");
        send_byte("a");
        send_byte("A");
        send_byte("b");
        send_byte("B");
        send_byte("9");
        send_byte(CH_LF);
        send_byte(8'h55);
        new_body = 1'b1;
        send_byte("0");
        send_byte(CH_LF);

        while (sent_n < ITEM_TARGET)
        begin
            quiet       = (sent_n >= 800 && sent_n < 1050);
            tx_idle_pct = quiet ? 0 : IDLE_PCT;
            rx_idle_pct = quiet ? 0 : IDLE_PCT;
            if (!held && sent_n >= 300)
            begin
                // keep offering while the receiver holds off
                held        = 1'b1;
                hold_req    = 1'b1;
                tx_idle_pct = 0;
                new_body    = 1'b1;
                send_chunk(40);
            end
            else if (!paused && sent_n >= 600)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0) @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 72)
                    send_body();
                else if (pick < 82)
                begin
                    // body cut off inside the data
                    new_body = 1'b1;
                    len = chunk_len();
                    send_size_line(48'(len));
                    repeat ($urandom_range(len - 1)) send_byte(8'($urandom));
                end
                else if (pick < 90)
                begin
                    new_body = 1'b1;
                    if ($urandom_range(2) == 0)
                        send_size_line(48'hFFFF_FFFF);
                    else
                        send_size_line({12'($urandom_range(1, 4095)), 4'($urandom),
                                        32'($urandom)});
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(3, 15))
                    begin
                        new_body = ($urandom_range(7) == 0);
                        send_byte(8'($urandom));
                    end
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
